@@ hdl/ara_pkg.sv @@
// ----------------------------------------------------------------------------
// ara_pkg
// Shared types and constants of the aligned staging-ring allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ara_pkg;

  // Field widths of the request and result items.
  localparam int unsigned SIZE_W  = 25;
  localparam int unsigned ALIGN_W = 4;

  // Configuration port geometry.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register index of the ring size register.
  localparam int unsigned REG_RING_SIZE = 0;

  // Request codes carried in the mode field.
  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_RESET = 1'b1
  } mode_t;

endpackage

`default_nettype wire

@@ hdl/ara_req_if.sv @@
// ----------------------------------------------------------------------------
// ara_req_if
// Request channel of the allocator: valid/ready handshake and request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ara_req_if;

  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [ara_pkg::SIZE_W-1:0]    alloc_size;
  logic [ara_pkg::ALIGN_W-1:0]   align_log2;

  modport source (output valid, mode, alloc_size, align_log2, input ready);
  modport sink   (input valid, mode, alloc_size, align_log2, output ready);

endinterface

`default_nettype wire

@@ hdl/ara_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ara_rsp_if
// Result channel of the allocator: valid/ready handshake and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface ara_rsp_if;

  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [ara_pkg::SIZE_W-1:0]  region_offset;
  logic                        wrapped;
  logic                        defragmented;
  logic                        frag_critical;
  logic                        memory_pressure;
  logic [ara_pkg::SIZE_W-1:0]  free_after;

  modport source (output valid, granted, region_offset, wrapped, defragmented,
                  frag_critical, memory_pressure, free_after, input ready);
  modport sink   (input valid, granted, region_offset, wrapped, defragmented,
                  frag_critical, memory_pressure, free_after, output ready);

endinterface

`default_nettype wire

@@ hdl/aligned_ring_allocator.sv @@
// ----------------------------------------------------------------------------
// aligned_ring_allocator
// Bump allocator over a staging ring with power-of-two alignment and wrap.
// ----------------------------------------------------------------------------
// Each request item is either an allocation (size and log2 alignment) or a
// ring reset. An item is captured in an input register, and in the cycle it
// moves to the result register the offset, waste and counter state is updated
// in one pass, so the block takes one item per clock while the result side is
// not stalled. A result is registered when its item moves on from the input
// register, and it can be taken once the result side is ready. The rate is
// set by the update loop on the ring offset, the wasted-byte total and the
// request and failure counters. A stalled result holds in the result register
// while the input register still takes one more item. The ring size register
// (byte address 0) may only be written while no item is in flight; the usable
// size is the smaller of that register and MAX_RING_BYTES. There is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module aligned_ring_allocator (
  input  wire logic                               clk,
  input  wire logic                               rst,
  ara_req_if.sink                                 req,
  ara_rsp_if.source                               rsp,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [ara_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [ara_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [ara_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready
);

  localparam int unsigned SizeW  = ara_pkg::SIZE_W;
  localparam int unsigned WasteW = 40;
  localparam int unsigned CntW   = 32;
  localparam int unsigned AlignSpanW = 16;
  localparam int unsigned MAX_RING_BYTES = 16777216;
  localparam logic [SizeW-1:0] RingReset = SizeW'(1048576);

  // Saturating helpers for the waste total and the event counters.
  function automatic logic [WasteW-1:0] sat_add_waste(input logic [WasteW-1:0] a,
                                                     input logic [SizeW-1:0]  b);
    logic [WasteW:0] s;
    s = (WasteW+1)'(a) + (WasteW+1)'(b);
    return s[WasteW] ? {WasteW{1'b1}} : s[WasteW-1:0];
  endfunction

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    return (&c) ? c : c + CntW'(1);
  endfunction

  // Waste is critical when twice the wasted bytes exceed a nonzero ring size.
  function automatic logic waste_crit(input logic [WasteW-1:0] w,
                                      input logic [SizeW-1:0]  r);
    return (r != '0) && ({w, 1'b0} > (WasteW+1)'(r));
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port. Index bits above the word offset select the register.
  // --------------------------------------------------------------------------
  logic [SizeW-1:0] ring_size;
  logic             cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[ara_pkg::APB_ADDR_W-1:2] == 1'(ara_pkg::REG_RING_SIZE));
  assign prdata  = cfg_hit ? ara_pkg::APB_DATA_W'(ring_size) : '0;

  // --------------------------------------------------------------------------
  // Pipeline control: input register feeds the result register, which may
  // stall. Allocator state advances only when an item moves forward.
  // --------------------------------------------------------------------------
  logic                 s1_valid;
  logic                 s1_mode;
  logic [SizeW-1:0]     s1_size;
  logic [3:0]           s1_lg;
  logic                 out_valid;
  logic                 advance;

  assign advance   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || advance;

  // Allocator state.
  logic [SizeW-1:0]  next_offset;
  logic [WasteW-1:0] wasted_total;
  logic [CntW-1:0]   request_count;
  logic [CntW-1:0]   failure_count;

  // --------------------------------------------------------------------------
  // Allocation datapath.
  // --------------------------------------------------------------------------
  logic [SizeW-1:0]      ring_eff;
  logic [AlignSpanW-1:0] align_mask;
  logic [SizeW:0]        aligned;
  logic [SizeW+1:0]      end1;
  logic                  fit1;
  logic                  fit2;
  logic [AlignSpanW-1:0] pad;
  logic [SizeW-1:0]      tail;
  logic [WasteW-1:0]     waste_pad;
  logic [WasteW-1:0]     waste_tail;

  // Usable ring size is the register clamped to the maximum supported ring.
  assign ring_eff = (31'(ring_size) > 31'(MAX_RING_BYTES)) ?
                    SizeW'(MAX_RING_BYTES) : ring_size;

  assign align_mask = AlignSpanW'((AlignSpanW'(1) << s1_lg) - AlignSpanW'(1));
  assign aligned    = ((SizeW+1)'(next_offset) + (SizeW+1)'(align_mask)) &
                      ~((SizeW+1)'(align_mask));
  assign end1       = (SizeW+2)'(aligned) + (SizeW+2)'(s1_size);
  assign fit1       = end1 <= (SizeW+2)'(ring_eff);
  assign fit2       = s1_size <= ring_eff;
  assign pad        = AlignSpanW'(aligned - (SizeW+1)'(next_offset));
  // If the ring shrank below the current offset, the tail counted is zero.
  assign tail       = (ring_eff > next_offset) ? ring_eff - next_offset : '0;
  assign waste_pad  = sat_add_waste(wasted_total, SizeW'(pad));
  assign waste_tail = sat_add_waste(wasted_total, tail);

  logic [SizeW-1:0]  offset_next;
  logic [WasteW-1:0] waste_next;
  logic [CntW-1:0]   req_cnt_next;
  logic [CntW-1:0]   fail_cnt_next;
  logic              granted_next;
  logic [SizeW-1:0]  region_next;
  logic              wrapped_next;
  logic              defrag_next;
  logic              crit_next;
  logic              press_next;
  logic [SizeW-1:0]  free_next;

  always_comb begin
    offset_next   = next_offset;
    waste_next    = wasted_total;
    req_cnt_next  = request_count;
    fail_cnt_next = failure_count;
    granted_next  = 1'b0;
    region_next   = '0;
    wrapped_next  = 1'b0;
    defrag_next   = 1'b0;
    if (s1_mode == ara_pkg::MODE_RESET) begin
      offset_next = '0;
      waste_next  = '0;
    end else begin
      req_cnt_next = sat_inc(request_count);
      if (fit1) begin
        // Fits after rounding up: alignment padding counts as waste.
        granted_next = 1'b1;
        region_next  = aligned[SizeW-1:0];
        offset_next  = end1[SizeW-1:0];
        waste_next   = waste_pad;
      end else begin
        // Wrap to the start of the ring and give up the tail.
        wrapped_next = 1'b1;
        offset_next  = '0;
        if (fit2) begin
          granted_next = 1'b1;
          offset_next  = s1_size;
          waste_next   = waste_tail;
        end else if (waste_crit(waste_tail, ring_eff)) begin
          // The ring is cleared and the request retried from offset zero.
          // The retry wraps again, wastes the whole ring and fails too.
          defrag_next   = 1'b1;
          waste_next    = WasteW'(ring_eff);
          fail_cnt_next = sat_inc(sat_inc(failure_count));
        end else begin
          waste_next    = waste_tail;
          fail_cnt_next = sat_inc(failure_count);
        end
      end
    end
    crit_next  = waste_crit(waste_next, ring_eff);
    press_next = (req_cnt_next != '0) &&
                 (((CntW+4)'(fail_cnt_next) * (CntW+4)'(10) > (CntW+4)'(req_cnt_next)) ||
                  crit_next);
    free_next  = (ring_eff > offset_next) ? ring_eff - offset_next : '0;
  end

  // --------------------------------------------------------------------------
  // Registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size     <= RingReset;
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      next_offset   <= '0;
      wasted_total  <= '0;
      request_count <= '0;
      failure_count <= '0;
    end else begin
      if (psel && penable && pwrite && cfg_hit) begin
        ring_size <= pwdata[SizeW-1:0];
      end
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (advance) begin
        out_valid     <= 1'b1;
        next_offset   <= offset_next;
        wasted_total  <= waste_next;
        request_count <= req_cnt_next;
        failure_count <= fail_cnt_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  logic             out_granted;
  logic [SizeW-1:0] out_region;
  logic             out_wrapped;
  logic             out_defrag;
  logic             out_crit;
  logic             out_press;
  logic [SizeW-1:0] out_free;

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_mode <= req.mode;
      s1_size <= req.alloc_size;
      s1_lg   <= req.align_log2;
    end
    if (advance) begin
      out_granted <= granted_next;
      out_region  <= region_next;
      out_wrapped <= wrapped_next;
      out_defrag  <= defrag_next;
      out_crit    <= crit_next;
      out_press   <= press_next;
      out_free    <= free_next;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.granted         = out_granted;
  assign rsp.region_offset   = out_region;
  assign rsp.wrapped         = out_wrapped;
  assign rsp.defragmented    = out_defrag;
  assign rsp.frag_critical   = out_crit;
  assign rsp.memory_pressure = out_press;
  assign rsp.free_after      = out_free;

endmodule

`default_nettype wire

@@ sim/aligned_ring_allocator_test.sv @@
// ----------------------------------------------------------------------------
// aligned_ring_allocator_test
// Self-checking regression for the aligned staging-ring allocator.
// ----------------------------------------------------------------------------
// Request items are driven through the request channel with random gaps. Each
// accepted item is run through a cycle-free predictor of the allocator, and
// each result item is compared field by field with the oldest prediction.
// The ring size register is written and read back over the APB port between
// phases, only while nothing is in flight. A short directed part covers the
// corner cases. Random phases with many ring sizes follow. Once in a while
// the result side holds off for a long stretch so the block backs up.
// ----------------------------------------------------------------------------

// One result item as it leaves the block.
typedef struct packed {
  logic                       granted;
  logic [ara_pkg::SIZE_W-1:0] region_offset;
  logic                       wrapped;
  logic                       defragmented;
  logic                       frag_critical;
  logic                       memory_pressure;
  logic [ara_pkg::SIZE_W-1:0] free_after;
} alloc_result_t;

localparam longint unsigned RING_LIMIT = 64'd16777216;
localparam longint unsigned WASTE_SAT  = 64'hFF_FFFF_FFFF;

// Tracks the ring state, predicts one result per request item and checks the
// results in order.
class ring_alloc_scoreboard;
  bit [24:0]     ring_size_reg;
  bit [24:0]     next_offset;
  bit [39:0]     wasted_bytes;
  bit [31:0]     wrap_count;
  bit [24:0]     largest_free;
  bit [31:0]     request_count;
  bit [31:0]     failure_count;
  alloc_result_t expected_q[$];
  int            error_count;

  function new();
    ring_size_reg = 25'd1048576;
    request_count = '0;
    failure_count = '0;
    error_count   = 0;
    clear_ring();
  endfunction

  function void set_ring_size(bit [24:0] value);
    ring_size_reg = value;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endfunction

  // Usable ring bytes are capped at the largest ring the block supports.
  function longint unsigned ring_bytes();
    longint unsigned r;
    r = 64'(ring_size_reg);
    return (r > RING_LIMIT) ? RING_LIMIT : r;
  endfunction

  // An empty ring never counts as fragmented.
  function bit waste_critical();
    longint unsigned r, w;
    r = ring_bytes();
    w = 64'(wasted_bytes);
    return (r != 0) && (w * 2 > r);
  endfunction

  function void clear_ring();
    longint unsigned r;
    r = ring_bytes();
    next_offset  = '0;
    wasted_bytes = '0;
    wrap_count   = '0;
    largest_free = r[24:0];
  endfunction

  function void add_waste(longint unsigned bytes);
    longint unsigned sum;
    sum = 64'(wasted_bytes) + bytes;
    if (sum > WASTE_SAT) sum = WASTE_SAT;
    wasted_bytes = sum[39:0];
  endfunction

  // One placement attempt. A region that does not fit wastes the tail and
  // restarts at zero, where it is tried again without alignment padding.
  function bit try_place(longint unsigned bytes, int unsigned lg,
                         output longint unsigned start, inout bit wrapped);
    longint unsigned r, align, cur, aligned, pad, stop;
    r       = ring_bytes();
    align   = 64'd1 << lg;
    cur     = 64'(next_offset);
    aligned = (cur + align - 1) & ~(align - 1);
    pad     = aligned - cur;
    start   = 0;
    if (aligned + bytes > r) begin
      add_waste((r > cur) ? r - cur : 64'd0);
      if (wrap_count != '1) wrap_count++;
      next_offset = '0;
      aligned     = 0;
      pad         = 0;
      wrapped     = 1'b1;
    end
    if (aligned + bytes > r) return 1'b0;
    add_waste(pad);
    stop         = aligned + bytes;
    next_offset  = stop[24:0];
    stop         = r - stop;
    largest_free = stop[24:0];
    start        = aligned;
    return 1'b1;
  endfunction

  function void note_request(ara_pkg::mode_t mode, logic [24:0] bytes, logic [3:0] lg);
    alloc_result_t   res;
    longint unsigned start, r, fa, reqs, fails;
    bit              ok, wrapped, defrag, crit;
    ok      = 1'b0;
    wrapped = 1'b0;
    defrag  = 1'b0;
    start   = 0;
    if (mode == ara_pkg::MODE_RESET) begin
      clear_ring();
    end else begin
      if (request_count != '1) request_count++;
      ok = try_place(64'(bytes), 32'(lg), start, wrapped);
      if (!ok) begin
        if (failure_count != '1) failure_count++;
        // Too much waste: start the ring over and give the request one more try.
        if (waste_critical()) begin
          clear_ring();
          defrag = 1'b1;
          ok = try_place(64'(bytes), 32'(lg), start, wrapped);
          if (!ok && failure_count != '1) failure_count++;
        end
      end
      if (!ok) start = 0;
    end
    r     = ring_bytes();
    crit  = waste_critical();
    reqs  = 64'(request_count);
    fails = 64'(failure_count);
    fa    = (r > 64'(next_offset)) ? r - 64'(next_offset) : 64'd0;
    res.granted         = ok;
    res.region_offset   = start[24:0];
    res.wrapped         = wrapped;
    res.defragmented    = defrag;
    res.frag_critical   = crit;
    res.memory_pressure = (reqs != 0) && ((fails * 10 > reqs) || crit);
    res.free_after      = fa[24:0];
    expected_q = {expected_q, res};
  endfunction

  function void check_result(alloc_result_t got);
    alloc_result_t exp;
    string         diff;
    if (expected_q.size() == 0) begin
      flag_error("result item arrived with no request outstanding");
      return;
    end
    exp  = expected_q.pop_front();
    diff = "";
    if (got.granted !== exp.granted)
      diff = {diff, $sformatf(" granted %0d/%0d", exp.granted, got.granted)};
    if (got.region_offset !== exp.region_offset)
      diff = {diff, $sformatf(" region_offset %0d/%0d", exp.region_offset, got.region_offset)};
    if (got.wrapped !== exp.wrapped)
      diff = {diff, $sformatf(" wrapped %0d/%0d", exp.wrapped, got.wrapped)};
    if (got.defragmented !== exp.defragmented)
      diff = {diff, $sformatf(" defragmented %0d/%0d", exp.defragmented, got.defragmented)};
    if (got.frag_critical !== exp.frag_critical)
      diff = {diff, $sformatf(" frag_critical %0d/%0d", exp.frag_critical, got.frag_critical)};
    if (got.memory_pressure !== exp.memory_pressure)
      diff = {diff, $sformatf(" memory_pressure %0d/%0d",
                              exp.memory_pressure, got.memory_pressure)};
    if (got.free_after !== exp.free_after)
      diff = {diff, $sformatf(" free_after %0d/%0d", exp.free_after, got.free_after)};
    if (diff != "") flag_error({"result mismatch (expected/actual):", diff});
  endfunction
endclass

module aligned_ring_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles with no item moving on either channel before the run is declared
  // hung. The longest legal quiet stretch is the long result hold-off plus a
  // long request gap and a register write, a small fraction of this.
  localparam int WATCHDOG_LIMIT = 3000;
  // Length of the long result-side hold-off that backs the block up.
  localparam int PRESSURE_HOLD  = 250;
  localparam int PHASES         = 16;
  localparam int PHASE_ITEMS    = 108;
  localparam logic [ara_pkg::APB_ADDR_W-1:0] RING_SIZE_ADDR =
    ara_pkg::APB_ADDR_W'(4 * ara_pkg::REG_RING_SIZE);

  logic                           clk = 1'b0;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [ara_pkg::APB_ADDR_W-1:0] paddr;
  logic [ara_pkg::APB_DATA_W-1:0] pwdata;
  logic [ara_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  ara_req_if req_ch ();
  ara_rsp_if rsp_ch ();

  ring_alloc_scoreboard sb;
  alloc_result_t        seen;
  // When set, both channels run without idle cycles.
  bit                   calm;
  // Raised by the stimulus to ask the result side for one long hold-off.
  bit                   hold_request;
  int                   idle_cycles;

  aligned_ring_allocator dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle stretch lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one request item after a random gap and returns at the rising edge
  // that accepts it. Valid stays high afterwards, so the next call or settle()
  // decides at the next falling edge whether it drops or carries a new item.
  task automatic send_request(ara_pkg::mode_t mode, logic [ara_pkg::SIZE_W-1:0] bytes,
                              logic [ara_pkg::ALIGN_W-1:0] lg);
    int gap;
    gap = calm ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= mode;
    req_ch.alloc_size <= bytes;
    req_ch.align_log2 <= lg;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Stops offering items and waits until every predicted result has come
  // back, then lets the two-stage pipeline fall quiet.
  task automatic settle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes the ring size register, then reads it back. The block must be
  // idle, so callers settle() first.
  task automatic write_ring_size(logic [ara_pkg::APB_DATA_W-1:0] value);
    logic [ara_pkg::APB_DATA_W-1:0] want;
    want = {{(ara_pkg::APB_DATA_W - ara_pkg::SIZE_W){1'b0}}, value[ara_pkg::SIZE_W-1:0]};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RING_SIZE_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_ring_size(value[ara_pkg::SIZE_W-1:0]);
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      sb.flag_error($sformatf("ring_size read back %0d, wrote %0d", prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One random phase. Most allocation sizes are scaled to the ring so that
  // grants, wraps and waste build up; the rest are near-fit, zero, full-width
  // sizes and ring resets.
  task automatic run_random_phase(int count);
    longint unsigned r;
    r = sb.ring_bytes();
    for (int i = 0; i < count; i++) begin
      int                          roll;
      int unsigned                 span;
      ara_pkg::mode_t              mode;
      logic [ara_pkg::SIZE_W-1:0]  bytes;
      logic [ara_pkg::ALIGN_W-1:0] lg;
      roll = $urandom_range(0, 99);
      mode = ara_pkg::MODE_ALLOC;
      if (roll < 5) begin
        mode  = ara_pkg::MODE_RESET;
        bytes = ara_pkg::SIZE_W'($urandom());
      end else if (roll < 10) begin
        bytes = '0;
      end else if (roll < 20) begin
        bytes = ara_pkg::SIZE_W'($urandom());
      end else if (roll < 30) begin
        bytes = ara_pkg::SIZE_W'(r + 64'($urandom_range(0, 4)) - 64'd2);
      end else begin
        span  = (roll < 60) ? 32'(r / 32) : 32'(r / 4);
        bytes = ara_pkg::SIZE_W'($urandom_range(0, span));
      end
      lg = ($urandom_range(0, 99) < 85) ? ara_pkg::ALIGN_W'($urandom_range(0, 12))
                                        : ara_pkg::ALIGN_W'($urandom_range(13, 15));
      send_request(mode, bytes, lg);
    end
  endtask

  // Every accepted request is predicted and every accepted result checked at
  // the rising edge, before the block updates its outputs.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request(ara_pkg::mode_t'(req_ch.mode), req_ch.alloc_size,
                        req_ch.align_log2);
      if (rsp_ch.valid && rsp_ch.ready) begin
        seen.granted         = rsp_ch.granted;
        seen.region_offset   = rsp_ch.region_offset;
        seen.wrapped         = rsp_ch.wrapped;
        seen.defragmented    = rsp_ch.defragmented;
        seen.frag_critical   = rsp_ch.frag_critical;
        seen.memory_pressure = rsp_ch.memory_pressure;
        seen.free_after      = rsp_ch.free_after;
        sb.check_result(seen);
      end
    end
  end

  // Hang detection: counts cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("aligned_ring_allocator regression: fail");
      $finish;
    end
  end

  // Result side: ready changes once per falling edge. Random stalls come in
  // from pick_gap(); a hold request replaces them with one long stall that is
  // counted down here while the request side keeps offering items.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = PRESSURE_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    sb                = new();
    calm              = 1'b0;
    hold_request      = 1'b0;
    idle_cycles       = 0;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.mode       = ara_pkg::MODE_ALLOC;
    req_ch.alloc_size = '0;
    req_ch.align_log2 = '0;
    rsp_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Default ring after reset: zero-byte request, plain and aligned grants,
    // alignment far above 4 KiB, an impossible request that wraps, turns the
    // waste critical and fails its retry, an exact fit of the whole ring, a
    // zero-byte request sitting at the very end, and a ring reset.
    send_request(ara_pkg::MODE_ALLOC, 25'd0, 4'd0);
    send_request(ara_pkg::MODE_ALLOC, 25'd1, 4'd0);
    send_request(ara_pkg::MODE_ALLOC, 25'd16, 4'd12);
    send_request(ara_pkg::MODE_ALLOC, 25'd8, 4'd15);
    send_request(ara_pkg::MODE_ALLOC, 25'h1FF_FFFF, 4'd0);
    send_request(ara_pkg::MODE_ALLOC, 25'd1048576, 4'd0);
    send_request(ara_pkg::MODE_ALLOC, 25'd0, 4'd3);
    send_request(ara_pkg::MODE_RESET, 25'h1FF_FFFF, 4'd15);
    send_request(ara_pkg::MODE_ALLOC, 25'd100, 4'd4);
    settle();

    // Small ring: wraps that pile up waste until it is critical, then a
    // request larger than the ring that forces the defragmenting retry.
    write_ring_size(32'd4096);
    send_request(ara_pkg::MODE_ALLOC, 25'd3000, 4'd0);
    send_request(ara_pkg::MODE_ALLOC, 25'd2000, 4'd2);
    send_request(ara_pkg::MODE_ALLOC, 25'd3000, 4'd0);
    send_request(ara_pkg::MODE_ALLOC, 25'd4097, 4'd0);
    send_request(ara_pkg::MODE_RESET, 25'd0, 4'd0);
    send_request(ara_pkg::MODE_ALLOC, 25'd3000, 4'd0);
    settle();

    // Ring shrunk below the current offset: the tail is empty and the next
    // request wraps without adding waste.
    write_ring_size(32'd1000);
    send_request(ara_pkg::MODE_ALLOC, 25'd10, 4'd0);
    send_request(ara_pkg::MODE_ALLOC, 25'd1000, 4'd0);
    settle();

    // Empty ring: only zero-byte requests succeed and waste never goes
    // critical, so failures alone drive the pressure flag.
    write_ring_size(32'd0);
    send_request(ara_pkg::MODE_ALLOC, 25'd0, 4'd0);
    send_request(ara_pkg::MODE_ALLOC, 25'd1, 4'd5);
    send_request(ara_pkg::MODE_ALLOC, 25'd0, 4'd15);
    settle();

    // Register above the supported maximum: the ring is capped.
    write_ring_size(32'h01FF_FFFF);
    send_request(ara_pkg::MODE_ALLOC, 25'd16777216, 4'd12);
    send_request(ara_pkg::MODE_ALLOC, 25'd1, 4'd0);
    send_request(ara_pkg::MODE_RESET, 25'd0, 4'd0);
    settle();

    // Random phases. Ring state carries over between most phases, so a new
    // smaller ring often starts below the old offset.
    for (int p = 0; p < PHASES; p++) begin
      logic [ara_pkg::APB_DATA_W-1:0] ring;
      case ($urandom_range(0, 10))
        0:       ring = 32'd0;
        1:       ring = 32'd1;
        2:       ring = 32'd64;
        3:       ring = 32'd1000;
        4:       ring = 32'd4096;
        5:       ring = 32'd65536;
        6:       ring = 32'd1048576;
        7:       ring = 32'd16777216;
        8:       ring = 32'h01FF_FFFF;
        9:       ring = 32'($urandom_range(0, 8192));
        default: ring = 32'($urandom() & 32'h01FF_FFFF);
      endcase
      write_ring_size(ring);
      calm = (p % 5 == 4);
      if (p == 3 || p == 11) hold_request = 1'b1;
      run_random_phase(PHASE_ITEMS);
      settle();
    end

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("aligned_ring_allocator regression: pass");
    end else begin
      $display("aligned_ring_allocator regression: fail");
    end
    $finish;
  end

endmodule
